/* design/assert_macros.svh */
// Assertion helpers for the timer table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_SAME(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define CHK_NEXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define CHK_SAME(lbl, c, r, a, b)
`define CHK_NEXT(lbl, c, r, a, b)
`endif
`endif

/* design/ptt_pkg.sv */
`default_nettype none
package ptt_pkg;
    localparam int CHANNELS_DEF = 16;
    localparam int MAX_REPORTS = 16;
    localparam logic [62:0] DEFAULT_DELAY = 63'd16000000;
    localparam logic [62:0] MASK63 = {63{1'b1}};
    localparam logic [31:0] MASK32 = {32{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  timer_index;
        logic [62:0] now;
        logic [62:0] first_timeout;
        logic [62:0] interval;
        logic [31:0] count_limit;
        logic        unlimited;
        logic        clear_count;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  fired_channel;
        logic [31:0] fire_total;
        logic        finished;
        logic        last;
    } evt_t;
endpackage
`default_nettype wire

/* design/periodic_timer_table.sv */
// Periodic timer table.
// Command channel (cmd_valid, cmd_stall, cmd): one beat is a tick, an arm or a
// disarm. Arm and disarm update the channel without leaving the idle state. A
// tick scans the channels in index order and steps past each channel that is
// not due. A due channel with catch-up runs a restoring divide (lateness /
// interval), then a quotient increment step and an add/limit step and, when it
// keeps running with a nonzero interval, a shift-add multiply and a deadline add.
// cmd_stall stays high for the whole tick.
// Event channel (evt_valid, evt_stall, evt): one beat per firing, in index
// order, at most 16 per tick; last marks the final beat of the tick. One beat
// waits in a pending register until the next firing or the end of the scan
// decides its last flag, so the first beat appears after the second firing
// or after the scan ends. A stalled event holds the scan at the next firing.
// Reset disarms every channel and clears every fire total; no events are
// pending afterward.
`default_nettype none
`include "assert_macros.svh"
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      evt_valid,
    input  wire logic evt_stall,
    output evt_t      evt
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = $clog2(CHANNELS + 1);
    localparam int NW = $clog2(MAX_REPORTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ADV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t       state_reg;
    logic         armed_reg   [CHANNELS];
    logic [62:0]  dl_reg      [CHANNELS];
    logic [62:0]  per_reg     [CHANNELS];
    logic [31:0]  lim_reg     [CHANNELS];
    logic         off_reg     [CHANNELS];
    logic [31:0]  tot_reg     [CHANNELS];
    logic [SW-1:0] scan_reg;
    logic [NW-1:0] n_reg;
    logic [62:0]  now_reg;
    logic [62:0]  r_reg;
    logic [62:0]  q_reg;
    logic [62:0]  acc_reg;
    logic         sat_reg;
    logic [31:0]  fired_reg;
    logic [5:0]   step_reg;
    logic         pend_valid_reg;
    evt_t         pend_reg;
    logic         evt_valid_reg;
    evt_t         evt_reg;
    logic         done_reg;

    logic [CW-1:0] sel;
    logic [CW-1:0] arm_sel;
    logic          arm_ok;
    logic [62:0]   delay;
    logic [63:0]   arm_sum;
    logic [62:0]   arm_dl;
    logic [63:0]   div_r;
    logic          div_ge;
    logic [31:0]   fired_next;
    logic [32:0]   cur_sum;
    logic [31:0]   cur_sat;
    logic [31:0]   cur;
    logic          done;
    logic [64:0]   mul_t;
    logic [62:0]   adv;
    logic [63:0]   adv_sum;
    logic          scan_end;
    logic          due;
    logic          out_free;
    logic          evt_load;

    assign sel      = scan_reg[CW-1:0];
    assign arm_sel  = CW'(cmd.timer_index);
    assign arm_ok   = 32'(cmd.timer_index) < CHANNELS;
    assign delay    = (cmd.first_timeout != '0) ? cmd.first_timeout :
                      (cmd.interval != '0) ? cmd.interval : DEFAULT_DELAY;
    assign arm_sum  = {1'b0, cmd.now} + {1'b0, delay};
    assign arm_dl   = arm_sum[63] ? MASK63 : arm_sum[62:0];
    assign div_r    = {r_reg, q_reg[62]};
    assign div_ge   = div_r >= {1'b0, per_reg[sel]};
    assign fired_next = ((q_reg[62:32] != '0) || (q_reg[31:0] == MASK32)) ?
                        MASK32 : q_reg[31:0] + 32'd1;
    assign cur_sum  = {1'b0, tot_reg[sel]} + {1'b0, fired_reg};
    assign cur_sat  = cur_sum[32] ? MASK32 : cur_sum[31:0];
    assign cur      = (!off_reg[sel] && cur_sat > lim_reg[sel]) ? lim_reg[sel] : cur_sat;
    assign done     = !off_reg[sel] && cur >= lim_reg[sel];
    assign mul_t    = {1'b0, acc_reg, 1'b0} +
                      (fired_reg[31] ? {2'b00, per_reg[sel]} : 65'd0);
    assign adv      = sat_reg ? MASK63 : acc_reg;
    assign adv_sum  = {1'b0, dl_reg[sel]} + {1'b0, adv};
    assign scan_end = (32'(scan_reg) >= CHANNELS) || (32'(n_reg) >= MAX_REPORTS);
    assign due      = armed_reg[sel] && (dl_reg[sel] <= now_reg);
    assign out_free = !evt_valid_reg || !evt_stall;
    assign evt_load = pend_valid_reg && out_free &&
                      ((state_reg == ST_SCAN && scan_end) || state_reg == ST_EMIT);

    assign cmd_stall = (state_reg != ST_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            n_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                armed_reg[i] <= 1'b0;
                tot_reg[i]   <= '0;
            end
        end
        else
        begin
            if (evt_load)
                evt_valid_reg <= 1'b1;
            else if (!evt_stall)
                evt_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (op_t'(cmd.operation))
                            OP_TICK:
                            begin
                                now_reg   <= cmd.now;
                                scan_reg  <= '0;
                                n_reg     <= '0;
                                state_reg <= ST_SCAN;
                            end
                            OP_ARM:
                            begin
                                if (arm_ok)
                                begin
                                    dl_reg[arm_sel]    <= arm_dl;
                                    per_reg[arm_sel]   <= cmd.interval;
                                    lim_reg[arm_sel]   <= cmd.count_limit;
                                    off_reg[arm_sel]   <= cmd.unlimited;
                                    armed_reg[arm_sel] <= 1'b1;
                                    if (cmd.clear_count)
                                        tot_reg[arm_sel] <= '0;
                                end
                            end
                            OP_DISARM:
                            begin
                                if (arm_ok)
                                    armed_reg[arm_sel] <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        if (!pend_valid_reg)
                            state_reg <= ST_IDLE;
                        else if (out_free)
                        begin
                            evt_reg.fired_channel <= pend_reg.fired_channel;
                            evt_reg.fire_total    <= pend_reg.fire_total;
                            evt_reg.finished      <= pend_reg.finished;
                            evt_reg.last          <= 1'b1;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else if (due)
                    begin
                        if (per_reg[sel] != '0 && now_reg > dl_reg[sel])
                        begin
                            r_reg     <= '0;
                            q_reg     <= now_reg - dl_reg[sel];
                            step_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            fired_reg <= 32'd1;
                            step_reg  <= '0;
                            state_reg <= ST_ADD;
                        end
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                ST_DIV:
                begin
                    r_reg    <= div_ge ? 63'(div_r - {1'b0, per_reg[sel]}) : div_r[62:0];
                    q_reg    <= {q_reg[61:0], div_ge};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd62)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (step_reg == 6'd63)
                        fired_reg <= fired_next;
                    else
                    begin
                        tot_reg[sel]  <= cur;
                        done_reg      <= done;
                        acc_reg       <= '0;
                        sat_reg       <= 1'b0;
                        if (done)
                        begin
                            armed_reg[sel] <= 1'b0;
                            state_reg      <= ST_EMIT;
                        end
                        else if (per_reg[sel] != '0)
                            state_reg <= ST_MUL;
                        else
                            state_reg <= ST_EMIT;
                    end
                    step_reg <= '0;
                end
                ST_MUL:
                begin
                    acc_reg   <= mul_t[62:0];
                    if (mul_t[64:63] != 2'b00)
                        sat_reg <= 1'b1;
                    fired_reg <= {fired_reg[30:0], 1'b0};
                    step_reg  <= step_reg + 6'd1;
                    if (step_reg == 6'd31)
                        state_reg <= ST_ADV;
                end
                ST_ADV:
                begin
                    dl_reg[sel] <= adv_sum[63] ? MASK63 : adv_sum[62:0];
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                            evt_reg <= pend_reg;
                        pend_reg.fired_channel <= 4'(scan_reg);
                        pend_reg.fire_total    <= tot_reg[sel];
                        pend_reg.finished      <= done_reg;
                        pend_reg.last          <= 1'b0;
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + 1'b1;
                        scan_reg       <= scan_reg + 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    `CHK_SAME(a_stall_idle, clk, rst_n, !cmd_stall, state_reg == ST_IDLE && !pend_valid_reg)
    `CHK_NEXT(a_evt_hold, clk, rst_n, evt_valid && evt_stall, evt_valid && $stable(evt))
    `CHK_SAME(a_n_bound, clk, rst_n, 1'b1, 32'(n_reg) <= MAX_REPORTS)
    `CHK_NEXT(a_tick_start, clk, rst_n, cmd_valid && !cmd_stall && cmd.operation == OP_TICK,
              state_reg == ST_SCAN && scan_reg == '0)
endmodule
`default_nettype wire
